// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the address sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// When the condition holds, the expression must hold in the following cycle.
`define ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, cond, expr)
`endif
`endif

// ===== hdl/iiy_pkg.sv =====
// Types and codes shared by the (zp),Y address sequencer.
package iiy_pkg;

  localparam int InWidth  = 48;
  localparam int OutWidth = 40;

  localparam logic [1:0] CLS_READ  = 2'd0;
  localparam logic [1:0] CLS_RMW   = 2'd1;
  localparam logic [1:0] CLS_WRITE = 2'd2;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic        exec_fail;
    logic [7:0]  exec_result;
    logic [7:0]  bus_read_data;
    logic [7:0]  index_y;
    logic [15:0] program_counter;
    logic [1:0]  access_class;
    logic        start_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  exec_operand;
    logic        exec_request;
    logic        pc_advance;
    logic [7:0]  bus_write_data;
    logic [15:0] bus_address;
    logic [1:0]  bus_access;
  } out_item_t;

endpackage

// ===== hdl/iiy_seq.sv =====
// Bus cycle sequencer for (zp),Y: state registers and per-beat next logic.
`include "assert_macros.svh"
module iiy_seq
  import iiy_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_accept,
  input  in_item_t  item,
  output out_item_t result
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_READ_LOW  = 3'd1,
    PH_READ_HIGH = 3'd2,
    PH_ADDRESS   = 3'd3,
    PH_OPERAND   = 3'd4,
    PH_MODIFY    = 3'd5,
    PH_WRITE     = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  zp_ptr, zp_ptr_next;
  logic [15:0] eff_addr, eff_addr_next;
  logic        page_crossed, page_crossed_next;
  logic [7:0]  held_value, held_value_next;
  logic [15:0] base;
  logic [15:0] sum;

  assign base = {item.bus_read_data, eff_addr[7:0]};
  assign sum  = base + {8'd0, item.index_y};

  always_comb begin
    result            = '0;
    result.status     = ST_BUSY;
    phase_next        = phase;
    zp_ptr_next       = zp_ptr;
    eff_addr_next     = eff_addr;
    page_crossed_next = page_crossed;
    held_value_next   = held_value;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          result.bus_access  = BUS_READ;
          result.bus_address = item.program_counter;
          result.pc_advance  = 1'b1;
          zp_ptr_next        = item.bus_read_data;
          phase_next         = PH_READ_LOW;
        end
      end
      PH_READ_LOW: begin
        result.bus_access  = BUS_READ;
        result.bus_address = {8'd0, zp_ptr};
        eff_addr_next      = {eff_addr[15:8], item.bus_read_data};
        zp_ptr_next        = zp_ptr + 8'd1;
        phase_next         = PH_READ_HIGH;
      end
      PH_READ_HIGH: begin
        result.bus_access  = BUS_READ;
        result.bus_address = {8'd0, zp_ptr};
        page_crossed_next  = (sum[15:8] != base[15:8]);
        eff_addr_next      = sum;
        phase_next         = PH_ADDRESS;
      end
      PH_ADDRESS: begin
        priority if (item.access_class == CLS_READ) begin
          if (!page_crossed) begin
            result.bus_access   = BUS_READ;
            result.bus_address  = eff_addr;
            result.exec_request = 1'b1;
            result.exec_operand = item.bus_read_data;
            result.status       = item.exec_fail ? ST_ERROR : ST_DONE;
            phase_next          = PH_IDLE;
          end else begin
            phase_next = PH_OPERAND;
          end
        end else if (item.access_class == CLS_RMW) begin
          phase_next = PH_OPERAND;
        end else if (item.access_class == CLS_WRITE) begin
          phase_next = PH_WRITE;
        end else begin
          result.status = ST_ERROR;
          phase_next    = PH_IDLE;
        end
      end
      PH_OPERAND: begin
        result.bus_access  = BUS_READ;
        result.bus_address = eff_addr;
        priority if (item.access_class == CLS_READ) begin
          result.exec_request = 1'b1;
          result.exec_operand = item.bus_read_data;
          result.status       = item.exec_fail ? ST_ERROR : ST_DONE;
          phase_next          = PH_IDLE;
        end else if (item.access_class == CLS_RMW) begin
          held_value_next = item.bus_read_data;
          phase_next      = PH_MODIFY;
        end else begin
          result.status = ST_ERROR;
          phase_next    = PH_IDLE;
        end
      end
      PH_MODIFY: begin
        // Dummy write of the original byte while the execute unit modifies it.
        result.bus_access     = BUS_WRITE;
        result.bus_address    = eff_addr;
        result.bus_write_data = held_value;
        result.exec_request   = 1'b1;
        result.exec_operand   = held_value;
        if (item.exec_fail) begin
          result.status = ST_ERROR;
          phase_next    = PH_IDLE;
        end else begin
          held_value_next = item.exec_result;
          phase_next      = PH_WRITE;
        end
      end
      PH_WRITE: begin
        priority if (item.access_class == CLS_RMW) begin
          result.bus_access     = BUS_WRITE;
          result.bus_address    = eff_addr;
          result.bus_write_data = held_value;
          result.status         = ST_DONE;
        end else if (item.access_class == CLS_WRITE) begin
          result.exec_request = 1'b1;
          if (item.exec_fail) begin
            result.status = ST_ERROR;
          end else begin
            result.bus_access     = BUS_WRITE;
            result.bus_address    = eff_addr;
            result.bus_write_data = item.exec_result;
            result.status         = ST_DONE;
          end
        end else begin
          result.status = ST_ERROR;
        end
        phase_next = PH_IDLE;
      end
      default: begin
        result.status = ST_ERROR;
        phase_next    = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      page_crossed <= 1'b0;
    end else if (in_accept) begin
      phase        <= phase_next;
      page_crossed <= page_crossed_next;
      zp_ptr       <= zp_ptr_next;
      eff_addr     <= eff_addr_next;
      held_value   <= held_value_next;
    end
  end

  // An idle bus cycle never carries an address.
  `ASSERT_ALWAYS(a_idle_bus_no_addr, (result.bus_access != BUS_NONE) || (result.bus_address == 16'd0))
  // A finished or failed instruction leaves the sequencer idle.
  `ASSERT_NEXT(a_end_to_idle, in_accept && (result.status != ST_BUSY), phase == PH_IDLE)
  // The opcode-operand fetch is always followed by the pointer low-byte read.
  `ASSERT_NEXT(a_adv_to_low, in_accept && result.pc_advance, phase == PH_READ_LOW)
  // Without an accepted beat the sequence does not move.
  `ASSERT_NEXT(a_hold_phase, !in_accept, $stable(phase))

endmodule

// ===== hdl/iiy_out_reg.sv =====
// Output register stage that holds one result beat until the sink takes it.
`include "assert_macros.svh"
module iiy_out_reg
  import iiy_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  out_item_t           result,
  output logic                in_ready,
  input  logic                in_valid,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutWidth-1:0] m_tdata
);

  out_item_t held;

  assign in_ready = !m_tvalid || m_tready;
  assign m_tdata  = {{(OutWidth - $bits(out_item_t)){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        held <= result;
      end
    end
  end

  // A waiting beat is never overwritten.
  `ASSERT_NEXT(a_hold_beat, m_tvalid && !m_tready, m_tvalid && $stable(held))
  // Each accepted beat shows up on the output the next cycle.
  `ASSERT_NEXT(a_beat_out, in_valid && in_ready, m_tvalid)
  // The padding bits stay zero.
  `ASSERT_ALWAYS(a_pad_zero, m_tdata[OutWidth-1:$bits(out_item_t)] == '0)

endmodule

// ===== hdl/indirect_indexed_y_address_sequencer_unit.sv =====
// Top level: (zp),Y bus cycle sequencer, one machine cycle per beat.
// The result of an accepted input beat is registered and appears in the next cycle.
// Throughput: one beat per clock; a new beat is taken while the result register
// is empty or being drained, so a stalled sink stalls the source after one beat.
// Reset (rst, synchronous, active high) returns the sequencer to idle, clears the
// page-cross flag and empties the result register.
module indirect_indexed_y_address_sequencer_unit
  import iiy_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // start_req, access_class, program_counter, index_y, bus_read_data,
  // exec_result, exec_fail, zero padding
  input  logic [InWidth-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // bus_access, bus_address, bus_write_data, pc_advance, exec_request,
  // exec_operand, status, zero padding
  output logic [OutWidth-1:0] m_tdata
);

  in_item_t  item;
  out_item_t result;
  logic      in_accept;

  assign item      = s_tdata[$bits(in_item_t)-1:0];
  assign in_accept = s_tvalid && s_tready;

  iiy_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .item      (item),
    .result    (result)
  );

  iiy_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .in_ready (s_tready),
    .in_valid (s_tvalid),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the (zp),Y sequencer: directed and random bus cycles against a predictor.
module tb_top;
  import iiy_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemBits = $bits(in_item_t);
  localparam int CycleBits = $bits(out_item_t);
  localparam logic [1:0] CLS_NONE = 2'd3;

  typedef enum logic [2:0] {
    Idle, ReadLow, ReadHigh, AddrCalc, FetchOperand, WriteBack, FinalWrite
  } seq_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InWidth-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;

  indirect_indexed_y_address_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t machine_cycle_q[$];
  out_item_t bus_cycle_q[$];
  int beats_sent = 0;
  int total_beats = 0;
  int directed_end = 0;
  int third_one = 0;
  int third_two = 0;
  int fail_count = 0;

  // Predictor state.
  seq_phase_e walk;
  logic [7:0] zp_ptr;
  logic [15:0] eff_addr;
  logic crossed;
  logic [7:0] held;

  function automatic out_item_t predict_bus_cycle(in_item_t c);
    out_item_t r;
    logic [15:0] base;
    logic [15:0] sum;
    r = '0;
    r.bus_access = BUS_NONE;
    r.status = ST_BUSY;
    case (walk)
      Idle: begin
        if (c.start_req) begin
          r.bus_access = BUS_READ;
          r.bus_address = c.program_counter;
          r.pc_advance = 1'b1;
          zp_ptr = c.bus_read_data;
          walk = ReadLow;
        end
      end
      ReadLow: begin
        r.bus_access = BUS_READ;
        r.bus_address = {8'h00, zp_ptr};
        eff_addr[7:0] = c.bus_read_data;
        zp_ptr = zp_ptr + 8'd1;
        walk = ReadHigh;
      end
      ReadHigh: begin
        r.bus_access = BUS_READ;
        r.bus_address = {8'h00, zp_ptr};
        base = {c.bus_read_data, eff_addr[7:0]};
        sum = base + {8'h00, c.index_y};
        crossed = (sum[15:8] != base[15:8]);
        eff_addr = sum;
        walk = AddrCalc;
      end
      AddrCalc: begin
        if (c.access_class == CLS_READ) begin
          if (!crossed) begin
            r.bus_access = BUS_READ;
            r.bus_address = eff_addr;
            r.exec_request = 1'b1;
            r.exec_operand = c.bus_read_data;
            r.status = c.exec_fail ? ST_ERROR : ST_DONE;
            walk = Idle;
          end else begin
            walk = FetchOperand;
          end
        end else if (c.access_class == CLS_RMW) begin
          walk = FetchOperand;
        end else if (c.access_class == CLS_WRITE) begin
          walk = FinalWrite;
        end else begin
          r.status = ST_ERROR;
          walk = Idle;
        end
      end
      FetchOperand: begin
        r.bus_access = BUS_READ;
        r.bus_address = eff_addr;
        if (c.access_class == CLS_READ) begin
          r.exec_request = 1'b1;
          r.exec_operand = c.bus_read_data;
          r.status = c.exec_fail ? ST_ERROR : ST_DONE;
          walk = Idle;
        end else if (c.access_class == CLS_RMW) begin
          held = c.bus_read_data;
          walk = WriteBack;
        end else begin
          r.status = ST_ERROR;
          walk = Idle;
        end
      end
      WriteBack: begin
        // The unmodified byte goes back to memory while the execute unit works on it.
        r.bus_access = BUS_WRITE;
        r.bus_address = eff_addr;
        r.bus_write_data = held;
        r.exec_request = 1'b1;
        r.exec_operand = held;
        if (c.exec_fail) begin
          r.status = ST_ERROR;
          walk = Idle;
        end else begin
          held = c.exec_result;
          walk = FinalWrite;
        end
      end
      FinalWrite: begin
        if (c.access_class == CLS_RMW) begin
          r.bus_access = BUS_WRITE;
          r.bus_address = eff_addr;
          r.bus_write_data = held;
          r.status = ST_DONE;
        end else if (c.access_class == CLS_WRITE) begin
          r.exec_request = 1'b1;
          if (c.exec_fail) begin
            r.status = ST_ERROR;
          end else begin
            r.bus_access = BUS_WRITE;
            r.bus_address = eff_addr;
            r.bus_write_data = c.exec_result;
            r.status = ST_DONE;
          end
        end else begin
          r.status = ST_ERROR;
        end
        walk = Idle;
      end
      default: begin
        r.status = ST_ERROR;
        walk = Idle;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Mostly random bytes, with the extremes showing up often.
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic push_idle(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = ItemBits'({$urandom, $urandom});
      it.start_req = 1'b0;
      machine_cycle_q.push_back(it);
    end
  endtask

  // One instruction's worth of bus cycles. The class seen from the operand cycle on
  // is late_cls, so a class change part way through can be provoked.
  task automatic add_instr(logic [1:0] cls, logic [1:0] late_cls, logic [15:0] pc,
                           logic [7:0] ptr, logic [7:0] lo, logic [7:0] hi,
                           logic [7:0] y, int fail_at, bit busy_start);
    in_item_t it;
    int n;
    bit wraps_page;
    wraps_page = (int'(lo) + int'(y)) > 255;
    case (cls)
      CLS_READ: n = wraps_page ? 5 : 4;
      CLS_RMW: n = 7;
      CLS_WRITE: n = 5;
      default: n = 4;
    endcase
    if (late_cls != cls) n = 7;
    for (int i = 0; i < n; i++) begin
      it.start_req = (i == 0) || (i == 1 && busy_start) || ($urandom_range(0, 9) == 0);
      it.access_class = (i < 3) ? 2'($urandom_range(0, 3)) : (i == 3) ? cls : late_cls;
      it.program_counter = (i == 0) ? pc : 16'($urandom);
      it.index_y = (i == 2) ? y : 8'($urandom);
      it.bus_read_data = (i == 0) ? ptr : (i == 1) ? lo : (i == 2) ? hi : 8'($urandom);
      it.exec_result = 8'($urandom);
      it.exec_fail = (i == fail_at) || (i < 3 && $urandom_range(0, 3) == 0);
      machine_cycle_q.push_back(it);
    end
  endtask

  always @(posedge clk) begin : drive
    logic go;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      walk = Idle;
      crossed = 1'b0;
      zp_ptr = '0;
      eff_addr = '0;
      held = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        bus_cycle_q.push_back(predict_bus_cycle(s_tdata[ItemBits-1:0]));
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        go = machine_cycle_q.size() != 0 &&
             $urandom_range(0, 99) >= (beats_sent < third_one ? 9 :
                                       beats_sent < third_two ? 53 : 0);
        // Hold off at a few points until the sequencer has drained completely.
        if ((beats_sent == directed_end || beats_sent == third_one ||
             beats_sent == third_two) && bus_cycle_q.size() != 0) go = 1'b0;
        if (go) begin
          s_tvalid <= 1'b1;
          s_tdata <= InWidth'(machine_cycle_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[CycleBits-1:0];
        if (bus_cycle_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none got %h", $time, got);
          fail_count++;
        end else begin
          want = bus_cycle_q.pop_front();
          check_field("bus_access", want.bus_access, got.bus_access);
          check_field("bus_address", want.bus_address, got.bus_address);
          check_field("bus_write_data", want.bus_write_data, got.bus_write_data);
          check_field("pc_advance", want.pc_advance, got.pc_advance);
          check_field("exec_request", want.exec_request, got.exec_request);
          check_field("exec_operand", want.exec_operand, got.exec_operand);
          check_field("status", want.status, got.status);
        end
      end
      m_tready <= $urandom_range(0, 99) >= (beats_sent < third_one ? 53 :
                                            beats_sent < third_two ? 9 : 0);
    end
  end

  initial begin
    int pick;
    logic [1:0] cls;
    logic [1:0] late;
    int fail_at;

    // Directed part.
    push_idle(1);
    // Pointer at the top of page zero, no page cross, execute unit fails.
    add_instr(CLS_READ, CLS_READ, 16'hFFFF, 8'hFF, 8'h10, 8'h20, 8'h00, 3, 1'b0);
    // Page cross that also wraps the whole address space.
    add_instr(CLS_READ, CLS_READ, 16'h0000, 8'h00, 8'hFF, 8'hFF, 8'hFF, -1, 1'b0);
    // Read-modify-write with the execute unit failing on the modify cycle.
    add_instr(CLS_RMW, CLS_RMW, 16'h1234, 8'h80, 8'h40, 8'h12, 8'h05, 5, 1'b0);
    add_instr(CLS_WRITE, CLS_WRITE, 16'hC000, 8'h7F, 8'hF0, 8'h33, 8'h20, -1, 1'b0);
    // No access class, with a start request arriving while busy.
    add_instr(CLS_NONE, CLS_NONE, 16'h8001, 8'h01, 8'h55, 8'hAA, 8'h80, -1, 1'b1);
    directed_end = machine_cycle_q.size();

    // Random part: mostly well-formed instructions, some with class changes.
    while (machine_cycle_q.size() < 1900) begin
      pick = $urandom_range(0, 99);
      cls = pick < 35 ? CLS_READ : pick < 65 ? CLS_RMW : pick < 95 ? CLS_WRITE : CLS_NONE;
      late = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : cls;
      fail_at = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 6) : -1;
      add_instr(cls, late, 16'($urandom), pick_byte(), pick_byte(), pick_byte(),
                pick_byte(), fail_at, $urandom_range(0, 19) == 0);
      if ($urandom_range(0, 7) == 0) push_idle($urandom_range(1, 3));
    end
    total_beats = machine_cycle_q.size();
    third_one = total_beats / 3;
    third_two = 2 * total_beats / 3;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (beats_sent < total_beats) @(posedge clk);
    while (bus_cycle_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && bus_cycle_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
